FILE: rtl/core/set_assoc_cache_lru_sim_core_assert.svh
// assertion helpers for the cache tag core
`ifndef SET_ASSOC_CACHE_LRU_SIM_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_CORE_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_NOW(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error("sacl check failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(label, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error("sacl check failed");

`endif

FILE: rtl/core/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS = 8;
	localparam int AGE_WIDTH = 32;
	localparam int STAMP_W = 64;
	localparam int TAG_W = 32;
	localparam int CNT_W = 32;
	localparam int ADDR_W = 64;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;
	localparam int SETB_W = 3;
	localparam int BLKB_W = 6;
	localparam int WAYSU_W = 4;
	localparam int SHIFT_W = 7;

	localparam logic [STAMP_W-1:0] AGE_MAX = {STAMP_W{1'b1}} >> (STAMP_W - AGE_WIDTH);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_STORE  = 2'd1,
		KIND_MODIFY = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS_USED  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_SCAN,
		ST_EVICT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic read;
		logic eval;
		logic scan;
		logic evict;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic access;
		logic hit;
		logic free;
		logic scan_last;
	} stat_t;

	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sacl_ctrl.sv
`default_nettype none
module sacl_ctrl import sacl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read = 1'b1;
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.access && !stat.hit && !stat.free) begin
					state_nxt = ST_SCAN;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_nxt = ST_EVICT;
				end
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/sacl_dp.sv
`default_nettype none
module sacl_dp import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [KIND_W-1:0]     kind,
	input  logic [ADDR_W-1:0]     address,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	output logic                  done,
	output logic [1:0]            hits_now,
	output logic                  missed,
	output logic                  evicted,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      evict_total
);

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int SB_W = $clog2(MAX_SET_BITS + 1);

	// configuration
	logic [SETB_W-1:0] set_bits_q;
	logic [BLKB_W-1:0] block_bits_q;
	logic [WAYSU_W-1:0] ways_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= SETB_W'(1);
			block_bits_q <= BLKB_W'(1);
			ways_used_q <= WAYSU_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SET_BITS: set_bits_q <= cfg_data[SETB_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLKB_W-1:0];
				CFG_WAYS_USED: ways_used_q <= cfg_data[WAYSU_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SB_W-1:0] s_eff;
	logic [WCNT_W-1:0] e_eff;
	logic [WAY_W-1:0] e_last;

	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			s_eff = SB_W'(MAX_SET_BITS);
		end else begin
			s_eff = SB_W'(set_bits_q);
		end
		if (ways_used_q == '0) begin
			e_eff = WCNT_W'(1);
		end else if (int'(ways_used_q) > MAX_WAYS) begin
			e_eff = WCNT_W'(MAX_WAYS);
		end else begin
			e_eff = WCNT_W'(ways_used_q);
		end
		e_last = WAY_W'(e_eff - WCNT_W'(1));
	end

	// address split
	logic [ADDR_W-1:0] addr_blk;
	logic [ADDR_W-1:0] addr_tag;
	logic [SHIFT_W-1:0] tag_shift;
	logic [MAX_SET_BITS-1:0] set_mask;
	logic [MAX_SET_BITS-1:0] set_idx;
	logic [TAG_W-1:0] tag_in;

	always_comb begin
		addr_blk = address >> block_bits_q;
		for (int i = 0; i < MAX_SET_BITS; i++) begin
			set_mask[i] = (i < int'(s_eff));
		end
		set_idx = addr_blk[MAX_SET_BITS-1:0] & set_mask;
		tag_shift = SHIFT_W'(block_bits_q) + SHIFT_W'(s_eff);
		addr_tag = address >> tag_shift[SHIFT_W-2:0];
		tag_in = tag_shift[SHIFT_W-1] ? '0 : addr_tag[TAG_W-1:0];
	end

	logic [KIND_W-1:0] kind_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			set_q <= set_idx;
			tag_q <= tag_in;
		end
	end

	// tag store, one row per set
	line_t [MAX_WAYS-1:0] mem_q [NUM_SETS];
	line_t [MAX_WAYS-1:0] rdata_q;
	line_t [MAX_WAYS-1:0] wr_row;
	logic row_ok_q;
	logic [NUM_SETS-1:0] row_valid_q;
	logic mem_we;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[set_q] <= wr_row;
		end
		if (cmd.read) begin
			rdata_q <= mem_q[set_q];
			row_ok_q <= row_valid_q[set_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (mem_we) begin
			row_valid_q[set_q] <= 1'b1;
		end
	end

	// lookup
	logic [MAX_WAYS-1:0] vld;
	logic [MAX_WAYS-1:0] hit_vec;
	logic [MAX_WAYS-1:0] free_vec;
	logic [WAY_W-1:0] hit_idx;
	logic [WAY_W-1:0] free_idx;
	logic [WAY_W-1:0] wr_sel;
	logic [WAY_W-1:0] scan_q;
	logic [WAY_W-1:0] victim_q;
	logic [STAMP_W-1:0] best_q;
	logic [STAMP_W-1:0] now_q;
	logic [STAMP_W-1:0] age_diff;
	logic [STAMP_W-1:0] age;
	logic access;

	always_comb begin
		access = (kind_t'(kind_q) != KIND_NONE);
		for (int w = 0; w < MAX_WAYS; w++) begin
			vld[w] = row_ok_q & rdata_q[w].valid;
			hit_vec[w] = (w < int'(e_eff)) & vld[w] & (rdata_q[w].tag == tag_q);
			free_vec[w] = (w < int'(e_eff)) & ~vld[w];
		end
		hit_idx = '0;
		free_idx = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_idx = WAY_W'(w);
			end
			if (free_vec[w]) begin
				free_idx = WAY_W'(w);
			end
		end
		if (cmd.evict) begin
			wr_sel = victim_q;
		end else if (|hit_vec) begin
			wr_sel = hit_idx;
		end else begin
			wr_sel = free_idx;
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == wr_sel) begin
				wr_row[w].valid = 1'b1;
				wr_row[w].tag = tag_q;
				wr_row[w].stamp = now_q;
			end else begin
				wr_row[w].valid = vld[w];
				wr_row[w].tag = rdata_q[w].tag;
				wr_row[w].stamp = rdata_q[w].stamp;
			end
		end
		mem_we = (cmd.eval && access && ((|hit_vec) || (|free_vec))) || cmd.evict;
		age_diff = now_q - rdata_q[scan_q].stamp;
		age = (age_diff > AGE_MAX) ? AGE_MAX : age_diff;
	end

	// oldest-way scan, one way a cycle
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			scan_q <= '0;
			best_q <= '0;
			victim_q <= '0;
		end else if (cmd.scan) begin
			scan_q <= scan_q + WAY_W'(1);
			if (age > best_q) begin
				best_q <= age;
				victim_q <= scan_q;
			end
		end
	end

	// totals and per-item result
	logic [CNT_W-1:0] hit_q;
	logic [CNT_W-1:0] miss_q;
	logic [CNT_W-1:0] evict_q;
	logic [1:0] hits_now_q;
	logic missed_q;
	logic evicted_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
			miss_q <= '0;
			evict_q <= '0;
			now_q <= '0;
			hits_now_q <= '0;
			missed_q <= 1'b0;
			evicted_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				hits_now_q <= '0;
				missed_q <= 1'b0;
				evicted_q <= 1'b0;
			end
			if (cmd.eval && access) begin
				if (|hit_vec) begin
					hit_q <= sat_inc(hit_q);
					hits_now_q <= 2'd1;
				end else begin
					miss_q <= sat_inc(miss_q);
					missed_q <= 1'b1;
				end
			end
			if (cmd.evict) begin
				evict_q <= sat_inc(evict_q);
				evicted_q <= 1'b1;
			end
			if (cmd.finish) begin
				now_q <= now_q + STAMP_W'(1);
				if (kind_t'(kind_q) == KIND_MODIFY) begin
					hit_q <= sat_inc(hit_q);
					hits_now_q <= hits_now_q + 2'd1;
				end
			end
		end
	end

	assign stat.access = access;
	assign stat.hit = |hit_vec;
	assign stat.free = |free_vec;
	assign stat.scan_last = (scan_q == e_last);

	assign done = done_q;
	assign hits_now = hits_now_q;
	assign missed = missed_q;
	assign evicted = evicted_q;
	assign hit_total = hit_q;
	assign miss_total = miss_q;
	assign evict_total = evict_q;

endmodule
`default_nettype wire

FILE: rtl/core/set_assoc_cache_lru_sim_core.sv
// Set-associative cache tag model with least-recently-used replacement.
// Request channel: pulse start with kind and address while busy is low; the
// request transfers on that edge and busy rises for the rest of the item.
// Config port: cfg_we with cfg_index / cfg_data writes set_bits, block_bits
// or ways_used; write only while idle.
// Result channel: done is high for one cycle with hits_now, missed, evicted
// and the running hit, miss and eviction totals; the receiver cannot stall,
// so the result must be taken in that cycle.
// Sequence: after the request edge the set row is read, then evaluated, then
// the item finishes and done rises; a miss on a full set adds an age scan over
// the ways in use and an eviction write before the finish. A new request can
// transfer at the edge that ends the done cycle, not before. The tag store is
// single-ported (one row of all ways per set) and the age scan covers one way
// a cycle. Ages are kept as access time stamps.
// Reset clears the set row valid flags and the totals and sets each
// configuration register to one; no clearing pass is needed, so requests are
// taken right after reset.
`default_nettype none
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [KIND_W-1:0]     kind,
	input  logic [ADDR_W-1:0]     address,
	output logic                  done,
	output logic [1:0]            hits_now,
	output logic                  missed,
	output logic                  evicted,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      evict_total
);

	cmd_t cmd;
	stat_t stat;

	sacl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sacl_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.address     (address),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.hits_now    (hits_now),
		.missed      (missed),
		.evicted     (evicted),
		.hit_total   (hit_total),
		.miss_total  (miss_total),
		.evict_total (evict_total)
	);

`include "set_assoc_cache_lru_sim_core_assert.svh"

	`SACL_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`SACL_ASSERT_NOW(a_done_idle, done, !busy)
	`SACL_ASSERT_NOW(a_evict_missed, done && evicted, missed)
	`SACL_ASSERT_NOW(a_miss_hits, done && missed, hits_now != 2'd2)

endmodule
`default_nettype wire

FILE: tb/tb_set_assoc_cache_lru_sim_core.sv
`timescale 1ns / 100ps
module tb_set_assoc_cache_lru_sim_core;
	import sacl_pkg::*;

	localparam int NUM_LINES = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 125;

	typedef enum logic [1:0] {
		OP_ACCESS,
		OP_CFG,
		OP_DRAIN
	} step_op_t;

	typedef enum logic [1:0] {
		ACC_HIT,
		ACC_FILL,
		ACC_EVICT
	} access_res_t;

	typedef struct {
		step_op_t              op;
		kind_t                 kind;
		logic [ADDR_W-1:0]     addr;
		cfg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
		int                    idle_cycles;
	} step_t;

	typedef struct packed {
		logic [1:0]       hits_now;
		logic             missed;
		logic             evicted;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] evict_total;
	} outcome_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_SET_BITS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic                  busy;
	kind_t                 kind = KIND_LOAD;
	logic [ADDR_W-1:0]     address = '0;
	logic                  done;
	logic [1:0]            hits_now;
	logic                  missed;
	logic                  evicted;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;
	logic [CNT_W-1:0]      evict_total;

	set_assoc_cache_lru_sim_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.address    (address),
		.done       (done),
		.hits_now   (hits_now),
		.missed     (missed),
		.evicted    (evicted),
		.hit_total  (hit_total),
		.miss_total (miss_total),
		.evict_total(evict_total)
	);

	// cache image kept alongside the block
	bit                 line_valid_m [NUM_LINES];
	logic [TAG_W-1:0]   line_tag_m   [NUM_LINES];
	logic [STAMP_W-1:0] line_age_m   [NUM_LINES];
	logic [CNT_W-1:0]   hit_cnt = '0;
	logic [CNT_W-1:0]   miss_cnt = '0;
	logic [CNT_W-1:0]   evict_cnt = '0;
	logic [SETB_W-1:0]  cur_set_bits = 3'd1;
	logic [BLKB_W-1:0]  cur_block_bits = 6'd1;
	logic [WAYSU_W-1:0] cur_ways = 4'd1;

	// configuration as seen while building the stimulus
	logic [SETB_W-1:0]  gen_set_bits = 3'd1;
	logic [BLKB_W-1:0]  gen_block_bits = 6'd1;
	logic [WAYSU_W-1:0] gen_ways = 4'd1;
	bit                 idle_on = 1'b1;

	step_t    step_q[$];
	outcome_t outcome_q[$];
	int       mismatches = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic access_res_t cache_access(input logic [ADDR_W-1:0] a);
		int s;
		int e;
		int b;
		int base;
		int victim;
		logic [TAG_W-1:0] tg;
		logic [STAMP_W-1:0] oldest;
		s = (cur_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cur_set_bits);
		e = (cur_ways == 0) ? 1 : ((cur_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cur_ways));
		b = int'(cur_block_bits);
		tg = (b + s >= 64) ? '0 : TAG_W'(a >> (b + s));
		base = int'((a >> b) & ((64'd1 << s) - 64'd1)) * DEF_MAX_WAYS;
		victim = 0;
		oldest = '0;
		for (int w = 0; w < e; w++) begin
			if (line_valid_m[base + w] && line_tag_m[base + w] == tg) begin
				hit_cnt = count_up(hit_cnt);
				line_age_m[base + w] = '0;
				return ACC_HIT;
			end
		end
		miss_cnt = count_up(miss_cnt);
		for (int w = 0; w < e; w++) begin
			if (!line_valid_m[base + w]) begin
				line_valid_m[base + w] = 1'b1;
				line_tag_m[base + w] = tg;
				line_age_m[base + w] = '0;
				return ACC_FILL;
			end
		end
		evict_cnt = count_up(evict_cnt);
		for (int w = 0; w < e; w++) begin
			if (line_age_m[base + w] > oldest) begin
				oldest = line_age_m[base + w];
				victim = w;
			end
		end
		line_tag_m[base + victim] = tg;
		line_age_m[base + victim] = '0;
		return ACC_EVICT;
	endfunction

	function automatic outcome_t run_cache_item(input kind_t k, input logic [ADDR_W-1:0] a);
		outcome_t o;
		access_res_t r;
		o = '0;
		if (k != KIND_NONE) begin
			r = cache_access(a);
			if (r == ACC_HIT)
				o.hits_now = o.hits_now + 2'd1;
			else
				o.missed = 1'b1;
			if (r == ACC_EVICT)
				o.evicted = 1'b1;
			if (k == KIND_MODIFY) begin
				r = cache_access(a);
				if (r == ACC_HIT)
					o.hits_now = o.hits_now + 2'd1;
				if (r == ACC_EVICT)
					o.evicted = 1'b1;
			end
		end
		for (int i = 0; i < NUM_LINES; i++) begin
			if (line_valid_m[i] && line_age_m[i] < AGE_MAX)
				line_age_m[i] = line_age_m[i] + 1'b1;
		end
		o.hit_total = hit_cnt;
		o.miss_total = miss_cnt;
		o.evict_total = evict_cnt;
		return o;
	endfunction

	function automatic void apply_config(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
		case (idx)
			CFG_SET_BITS:   cur_set_bits = d[SETB_W-1:0];
			CFG_BLOCK_BITS: cur_block_bits = d[BLKB_W-1:0];
			CFG_WAYS_USED:  cur_ways = d[WAYSU_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic add_access(input kind_t k, input logic [ADDR_W-1:0] a);
		step_t st;
		st.op = OP_ACCESS;
		st.kind = k;
		st.addr = a;
		st.idx = CFG_SET_BITS;
		st.data = '0;
		st.idle_cycles = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
		step_q.push_back(st);
	endtask

	task automatic add_step(input step_op_t op, input cfg_idx_t idx, input logic [5:0] d);
		step_t st;
		st.op = op;
		st.kind = KIND_LOAD;
		st.addr = '0;
		st.idx = idx;
		st.data = d;
		st.idle_cycles = 0;
		step_q.push_back(st);
	endtask

	// wait for the block to go idle, then rewrite all three registers
	task automatic set_config(input logic [2:0] sb, input logic [5:0] bb, input logic [3:0] wu);
		add_step(OP_DRAIN, CFG_SET_BITS, '0);
		add_step(OP_CFG, CFG_SET_BITS, {3'd0, sb});
		add_step(OP_CFG, CFG_BLOCK_BITS, bb);
		add_step(OP_CFG, CFG_WAYS_USED, {2'd0, wu});
		gen_set_bits = sb;
		gen_block_bits = bb;
		gen_ways = wu;
	endtask

	// mostly a handful of tags crowding two sets, so fills, hits and evictions all occur
	function automatic logic [ADDR_W-1:0] pick_address();
		int s;
		int e;
		int b;
		int r;
		logic [ADDR_W-1:0] off;
		s = (gen_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(gen_set_bits);
		e = (gen_ways == 0) ? 1 : ((gen_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(gen_ways));
		b = int'(gen_block_bits);
		r = $urandom_range(0, 9);
		off = {$urandom, $urandom};
		if (r < 7)
			return (64'($urandom_range(0, e + 3)) << (b + s)) |
				(64'($urandom_range(0, 1)) << b) | (off & ((64'd1 << b) - 64'd1));
		else if (r < 9)
			return off;
		else
			return 64'($urandom_range(0, 255));
	endfunction

	function automatic kind_t pick_kind();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return KIND_NONE;
		else if (r < 6)
			return KIND_LOAD;
		else if (r < 11)
			return KIND_STORE;
		else
			return KIND_MODIFY;
	endfunction

	// sender: one transfer per start/busy handshake, register writes only when idle
	always @(posedge clk) begin
		logic go_start;
		logic go_we;
		go_start = 1'b0;
		go_we = 1'b0;
		if (arst_n) begin
			if (start && !busy)
				outcome_q.push_back(run_cache_item(kind, address));
			go_start = start && busy;
			if (!go_start && step_q.size() > 0) begin
				if (step_q[0].idle_cycles > 0) begin
					step_q[0].idle_cycles = step_q[0].idle_cycles - 1;
				end else begin
					case (step_q[0].op)
						OP_ACCESS: begin
							go_start = 1'b1;
							kind <= step_q[0].kind;
							address <= step_q[0].addr;
							void'(step_q.pop_front());
						end
						OP_CFG: begin
							if (outcome_q.size() == 0) begin
								go_we = 1'b1;
								cfg_index <= step_q[0].idx;
								cfg_data <= step_q[0].data;
								apply_config(step_q[0].idx, step_q[0].data);
								void'(step_q.pop_front());
							end
						end
						default: begin
							if (outcome_q.size() == 0)
								void'(step_q.pop_front());
						end
					endcase
				end
			end
			start <= go_start;
			cfg_we <= go_we;
		end
	end

	task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result with no transfer pending, expected none, actual hits %0d",
					$time, hits_now);
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("hits_now", 64'(want.hits_now), 64'(hits_now));
				check_field("missed", 64'(want.missed), 64'(missed));
				check_field("evicted", 64'(want.evicted), 64'(evicted));
				check_field("hit_total", 64'(want.hit_total), 64'(hit_total));
				check_field("miss_total", 64'(want.miss_total), 64'(miss_total));
				check_field("evict_total", 64'(want.evict_total), 64'(evict_total));
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_LINES; i++) begin
			line_valid_m[i] = 1'b0;
			line_tag_m[i] = '0;
			line_age_m[i] = '0;
		end

		// reset configuration: one way, two sets
		add_access(KIND_LOAD, 64'd0);
		add_access(KIND_LOAD, 64'd1);
		add_access(KIND_STORE, 64'd2);
		add_access(KIND_MODIFY, 64'd4);
		add_access(KIND_LOAD, 64'd0);
		add_access(KIND_NONE, 64'd0);
		add_access(KIND_LOAD, {ADDR_W{1'b1}});
		// no set bits, no offset, zero ways
		set_config(3'd0, 6'd0, 4'd0);
		add_access(KIND_LOAD, 64'd5);
		add_access(KIND_MODIFY, 64'd5);
		add_access(KIND_LOAD, 64'd6);
		// set bits above the limit and a shift past the address width
		set_config(3'd7, 6'd63, 4'd15);
		add_access(KIND_LOAD, 64'h8000_0000_0000_0000);
		add_access(KIND_LOAD, 64'd0);
		add_access(KIND_STORE, {ADDR_W{1'b1}});
		add_access(KIND_MODIFY, 64'd1);
		// shift of exactly 64
		set_config(3'd6, 6'd58, 4'd8);
		add_access(KIND_LOAD, 64'h0400_0000_0000_0000);
		add_access(KIND_LOAD, 64'd123);
		// tag taken from the upper word, truncated
		set_config(3'd6, 6'd26, 4'd2);
		add_access(KIND_LOAD, 64'hFFFF_FFFF_0000_0000);
		add_access(KIND_LOAD, 64'h0000_0001_0000_0000);
		add_access(KIND_LOAD, 64'h0000_0002_0000_0000);
		add_access(KIND_STORE, 64'h0000_0001_0000_0000);
		add_access(KIND_NONE, 64'h5555_5555_5555_5555);

		for (int p = 0; p < PHASES; p++) begin
			idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (p == 0)
				set_config(3'd6, 6'd1, 4'd8);
			else if (p == 1)
				set_config(3'd0, 6'd0, 4'd1);
			else if ($urandom_range(0, 3) == 0)
				set_config(3'($urandom_range(0, 7)), 6'($urandom_range(56, 63)),
					4'($urandom_range(0, 15)));
			else
				set_config(3'($urandom_range(0, 7)), 6'($urandom_range(0, 12)),
					4'($urandom_range(0, 15)));
			for (int n = 0; n < PHASE_ITEMS; n++)
				add_access(pick_kind(), pick_address());
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (step_q.size() != 0 || outcome_q.size() != 0 || start)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sacl_pkg.sv
rtl/core/sacl_ctrl.sv
rtl/core/sacl_dp.sv
rtl/core/set_assoc_cache_lru_sim_core.sv
tb/tb_set_assoc_cache_lru_sim_core.sv
